>>> rtl/assert_macros.svh
// Assertion macros shared by the smoothing filter RTL.
// Included by the modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is high.
`define TSM_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define TSM_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/tsm_pkg.sv
// Shared types and constants of the 5x5 triangular smoothing filter.
// No dependencies; used by every module of the block but tsm_ram.
package tsm_pkg;

   // Field widths of the configuration registers.
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam int WIDTH_RESET  = 640;
   localparam int HEIGHT_RESET = 480;
   localparam int DIM_MIN      = 5;

   localparam int DEFAULT_MAX_WIDTH  = 1024;
   localparam int DEFAULT_MAX_HEIGHT = 4096;

   // Register index, taken from paddr[2].
   localparam logic [0:0] REG_IMAGE_WIDTH  = 1'b0;
   localparam logic [0:0] REG_IMAGE_HEIGHT = 1'b1;

   // Kernel: outer product of {1,2,3,2,1}.
   localparam int KSIZE  = 5;
   localparam int NLINES = 4;
   localparam logic [1:0] TRI_WEIGHT [KSIZE] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd1};

   localparam int PIX_W  = 8;
   localparam int VSUM_W = 12;   // 9 * 255
   localparam int SUM_W  = 15;   // 81 * 255

   // floor(s / 81) == (s * 25891) >> 21 for every s up to 81 * 255.
   localparam int DIV81_MULT_W = 15;
   localparam logic [DIV81_MULT_W-1:0] DIV81_MULT = 15'd25891;
   localparam int DIV81_SHIFT = 21;
   localparam int PROD_W = SUM_W + DIV81_MULT_W;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_in;
      logic             drain;
   } req_payload_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_out;
      logic             frame_end;
   } rsp_payload_type;

   // What the front end decided for one item.
   typedef struct packed {
      logic shift;    // pixel enters the window and line stores
      logic emit;     // item yields one result
      logic border;   // result lies on the two-pixel border
      logic last;     // result is the frame's last
   } item_tag_type;

endpackage

>>> rtl/tsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tsm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/tsm_csr.sv
// Configuration registers (image width and height) behind the APB-style port.
// Depends on tsm_pkg.
module tsm_csr #(
   parameter int MAX_WIDTH  = tsm_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = tsm_pkg::DEFAULT_MAX_HEIGHT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [tsm_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [tsm_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [tsm_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready,
   output logic [tsm_pkg::WIDTH_REG_W-1:0]     image_width,
   output logic [tsm_pkg::HEIGHT_REG_W-1:0]    image_height,
   output logic                                restart
);

   logic [tsm_pkg::WIDTH_REG_W-1:0]  width_ff,  width_in;
   logic [tsm_pkg::HEIGHT_REG_W-1:0] height_ff, height_in;
   logic                             write_fire;

   function automatic logic [31:0] clamp_dim(input logic [31:0] v, input logic [31:0] hi);
      logic [31:0] r;
      r = v;
      if (v < 32'(tsm_pkg::DIM_MIN)) begin
         r = 32'(tsm_pkg::DIM_MIN);
      end else if (v > hi) begin
         r = hi;
      end
      return r;
   endfunction

   assign pready     = 1'b1;
   assign write_fire = psel && penable && pwrite;
   assign restart    = write_fire;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (write_fire) begin
         case (paddr[2:2])
            tsm_pkg::REG_IMAGE_WIDTH: begin
               width_in = tsm_pkg::WIDTH_REG_W'(clamp_dim(
                  32'(pwdata[tsm_pkg::WIDTH_REG_W-1:0]), 32'(MAX_WIDTH)));
            end
            tsm_pkg::REG_IMAGE_HEIGHT: begin
               height_in = tsm_pkg::HEIGHT_REG_W'(clamp_dim(
                  32'(pwdata[tsm_pkg::HEIGHT_REG_W-1:0]), 32'(MAX_HEIGHT)));
            end
            default: begin
               width_in  = width_ff;
               height_in = height_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[2:2])
         tsm_pkg::REG_IMAGE_WIDTH:  prdata = tsm_pkg::CSR_DATA_W'(width_ff);
         tsm_pkg::REG_IMAGE_HEIGHT: prdata = tsm_pkg::CSR_DATA_W'(height_ff);
         default:                   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= tsm_pkg::WIDTH_REG_W'(tsm_pkg::WIDTH_RESET);
         height_ff <= tsm_pkg::HEIGHT_REG_W'(tsm_pkg::HEIGHT_RESET);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign image_width  = width_ff;
   assign image_height = height_ff;

endmodule

>>> rtl/tsm_ctrl.sv
// Front end: input handshake, raster position counters and result bookkeeping.
// Issues the line-store read for each pixel. Depends on tsm_pkg, assert_macros.svh.
`include "assert_macros.svh"

module tsm_ctrl #(
   parameter int MAX_WIDTH  = tsm_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = tsm_pkg::DEFAULT_MAX_HEIGHT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  tsm_pkg::req_payload_type          req_payload,
   output logic                              req_stall,
   input  logic [tsm_pkg::WIDTH_REG_W-1:0]   image_width,
   input  logic [tsm_pkg::HEIGHT_REG_W-1:0]  image_height,
   input  logic                              restart,
   input  logic                              s1_ready,
   output logic                              item_load,
   output tsm_pkg::item_tag_type             item_tag,
   output logic [tsm_pkg::PIX_W-1:0]         item_pixel,
   output logic [$clog2(MAX_WIDTH)-1:0]      item_col,
   output logic                              rd_en,
   output logic [$clog2(MAX_WIDTH)-1:0]      rd_addr
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int IROW_W = $clog2(MAX_HEIGHT + 1);
   localparam int OROW_W = $clog2(MAX_HEIGHT);

   logic [COL_W-1:0]  in_col_ff,  in_col_in;
   logic [IROW_W-1:0] in_row_ff,  in_row_in;
   logic [COL_W-1:0]  out_col_ff, out_col_in;
   logic [OROW_W-1:0] out_row_ff, out_row_in;

   logic        accept;
   logic        flushing;
   logic        is_pixel;
   logic        px_ready;
   logic        emit;
   logic        border;
   logic        last;
   logic [31:0] w32;
   logic [31:0] h32;
   logic [31:0] in_col_nx;
   logic [31:0] out_col_nx;

   assign w32 = 32'(image_width);
   assign h32 = 32'(image_height);

   assign req_stall = !s1_ready;
   assign accept    = req_valid && s1_ready;

   always_comb begin
      flushing = 32'(in_row_ff) >= h32;
      is_pixel = !flushing && !req_payload.drain;
      px_ready = (32'(in_row_ff) > 32'd2) ||
                 ((32'(in_row_ff) == 32'd2) && (32'(in_col_ff) >= 32'd2));
      emit     = flushing || (is_pixel && px_ready);
      border   = (32'(out_row_ff) < 32'd2) || (32'(out_col_ff) < 32'd2) ||
                 (32'(out_row_ff) + 32'd2 >= h32) || (32'(out_col_ff) + 32'd2 >= w32);
      last     = (32'(out_row_ff) + 32'd1 == h32) && (32'(out_col_ff) + 32'd1 == w32);
   end

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      in_col_nx  = 32'(in_col_ff) + 32'd1;
      out_col_nx = 32'(out_col_ff) + 32'd1;
      if (accept && is_pixel) begin
         if (in_col_nx >= w32) begin
            in_col_in = '0;
            in_row_in = in_row_ff + 1'b1;
         end else begin
            in_col_in = COL_W'(in_col_nx);
         end
      end
      if (accept && emit) begin
         if (last) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
         end else if (out_col_nx >= w32) begin
            out_col_in = '0;
            out_row_in = out_row_ff + 1'b1;
         end else begin
            out_col_in = COL_W'(out_col_nx);
         end
      end
      // a register write restarts the frame
      if (restart) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   // Drains outside the flush phase are taken and dropped here.
   assign item_load       = accept && (is_pixel || emit);
   assign item_tag.shift  = is_pixel;
   assign item_tag.emit   = emit;
   assign item_tag.border = border;
   assign item_tag.last   = last;
   assign item_pixel      = req_payload.pixel_in;
   assign item_col        = in_col_ff;
   assign rd_en           = accept && is_pixel;
   assign rd_addr         = in_col_ff;

   `TSM_ASSERT(a_col_in_row, clock, reset,
      32'(in_col_ff) < w32 && 32'(out_col_ff) < w32, "column counter beyond image width")
   `TSM_ASSERT(a_row_bound, clock, reset,
      32'(in_row_ff) <= h32 && 32'(out_row_ff) < h32, "row counter beyond image height")
   `TSM_ASSERT(a_frame_wrap, clock, reset,
      accept && emit && last && !restart |=> in_row_ff == '0 && in_col_ff == '0 &&
      out_row_ff == '0 && out_col_ff == '0, "counters not cleared after last result")

endmodule

>>> rtl/tsm_filter.sv
// Datapath: line-store column assembly, column sums, kernel sum, divide by 81
// and the result register. Depends on tsm_pkg, assert_macros.svh.
`include "assert_macros.svh"

module tsm_filter #(
   parameter int MAX_WIDTH = tsm_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         item_load,
   input  tsm_pkg::item_tag_type                        item_tag,
   input  logic [tsm_pkg::PIX_W-1:0]                    item_pixel,
   input  logic [$clog2(MAX_WIDTH)-1:0]                 item_col,
   output logic                                         s1_ready,
   input  logic [tsm_pkg::NLINES*tsm_pkg::PIX_W-1:0]    rd_data,
   output logic                                         wr_en,
   output logic [$clog2(MAX_WIDTH)-1:0]                 wr_addr,
   output logic [tsm_pkg::NLINES*tsm_pkg::PIX_W-1:0]    wr_data,
   output logic                                         rsp_valid,
   output tsm_pkg::rsp_payload_type                     rsp_payload,
   input  logic                                         rsp_stall
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int K     = tsm_pkg::KSIZE;
   localparam int VW    = tsm_pkg::VSUM_W;
   localparam int SW    = tsm_pkg::SUM_W;
   localparam int PW    = tsm_pkg::PIX_W;

   // stage 1: item with its line-store column
   logic                  s1_valid_ff, s1_valid_in;
   tsm_pkg::item_tag_type s1_tag_ff,   s1_tag_in;
   logic [PW-1:0]         s1_pixel_ff, s1_pixel_in;
   logic [COL_W-1:0]      s1_col_ff,   s1_col_in;

   // running weighted column sums of the window
   logic [VW-1:0]         vsum_ff [K];
   logic [VW-1:0]         vsum_in [K];

   // stage 2: window snapshot
   logic                  s2_valid_ff,  s2_valid_in;
   logic                  s2_border_ff, s2_border_in;
   logic                  s2_last_ff,   s2_last_in;
   logic [VW-1:0]         s2_vsum_ff [K];
   logic [VW-1:0]         s2_vsum_in [K];

   // stage 3: kernel sum
   logic                  s3_valid_ff,  s3_valid_in;
   logic                  s3_border_ff, s3_border_in;
   logic                  s3_last_ff,   s3_last_in;
   logic [SW-1:0]         s3_sum_ff,    s3_sum_in;

   // result register
   logic                  out_valid_ff, out_valid_in;
   logic [PW-1:0]         out_pixel_ff, out_pixel_in;
   logic                  out_last_ff,  out_last_in;

   logic                  out_ready;
   logic                  s3_ready;
   logic                  s2_ready;
   logic                  s1_fire;
   logic                  s2_move;
   logic                  s3_move;
   logic [VW-1:0]         col_sum;
   logic [SW-1:0]         kern_sum;
   logic [tsm_pkg::PROD_W-1:0] prod;

   assign out_ready = !out_valid_ff || !rsp_stall;
   assign s3_ready  = !s3_valid_ff || out_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_fire   = s1_valid_ff && (!s1_tag_ff.emit || s2_ready);
   assign s1_ready  = !s1_valid_ff || s1_fire;
   assign s2_move   = s2_valid_ff && s3_ready;
   assign s3_move   = s3_valid_ff && out_ready;

   // Vertical weighted sum of the incoming column: lines 0..3, then the pixel.
   always_comb begin
      logic [PW-1:0] px;
      col_sum = '0;
      for (int j = 0; j < K; j++) begin
         if (j < tsm_pkg::NLINES) begin
            px = rd_data[PW*j +: PW];
         end else begin
            px = s1_pixel_ff;
         end
         col_sum = col_sum + VW'(tsm_pkg::TRI_WEIGHT[j]) * VW'(px);
      end
   end

   // Line store write-back: each line moves up by one.
   assign wr_en   = s1_fire && s1_tag_ff.shift;
   assign wr_addr = s1_col_ff;
   assign wr_data = {s1_pixel_ff, rd_data[tsm_pkg::NLINES*PW-1:PW]};

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_tag_in   = s1_tag_ff;
      s1_pixel_in = s1_pixel_ff;
      s1_col_in   = s1_col_ff;
      if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      if (item_load) begin
         s1_valid_in = 1'b1;
         s1_tag_in   = item_tag;
         s1_pixel_in = item_pixel;
         s1_col_in   = item_col;
      end
   end

   always_comb begin
      for (int j = 0; j < K; j++) begin
         vsum_in[j] = vsum_ff[j];
      end
      if (s1_fire && s1_tag_ff.shift) begin
         for (int j = 0; j < K - 1; j++) begin
            vsum_in[j] = vsum_ff[j+1];
         end
         vsum_in[K-1] = col_sum;
      end
   end

   always_comb begin
      s2_valid_in  = s2_valid_ff;
      s2_border_in = s2_border_ff;
      s2_last_in   = s2_last_ff;
      for (int j = 0; j < K; j++) begin
         s2_vsum_in[j] = s2_vsum_ff[j];
      end
      if (s2_move) begin
         s2_valid_in = 1'b0;
      end
      if (s1_fire && s1_tag_ff.emit) begin
         s2_valid_in  = 1'b1;
         s2_border_in = s1_tag_ff.border;
         s2_last_in   = s1_tag_ff.last;
         for (int j = 0; j < K; j++) begin
            s2_vsum_in[j] = vsum_in[j];
         end
      end
   end

   always_comb begin
      kern_sum = '0;
      for (int j = 0; j < K; j++) begin
         kern_sum = kern_sum + SW'(tsm_pkg::TRI_WEIGHT[j]) * SW'(s2_vsum_ff[j]);
      end
   end

   always_comb begin
      s3_valid_in  = s3_valid_ff;
      s3_border_in = s3_border_ff;
      s3_last_in   = s3_last_ff;
      s3_sum_in    = s3_sum_ff;
      if (s3_move) begin
         s3_valid_in = 1'b0;
      end
      if (s2_move) begin
         s3_valid_in  = 1'b1;
         s3_border_in = s2_border_ff;
         s3_last_in   = s2_last_ff;
         s3_sum_in    = kern_sum;
      end
   end

   // floor(sum / 81) by reciprocal multiply
   assign prod = tsm_pkg::PROD_W'(s3_sum_ff) * tsm_pkg::PROD_W'(tsm_pkg::DIV81_MULT);

   always_comb begin
      out_valid_in = out_valid_ff;
      out_pixel_in = out_pixel_ff;
      out_last_in  = out_last_ff;
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
      if (s3_move) begin
         out_valid_in = 1'b1;
         out_last_in  = s3_last_ff;
         if (s3_border_ff) begin
            out_pixel_in = '0;
         end else begin
            out_pixel_in = prod[tsm_pkg::DIV81_SHIFT +: PW];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int j = 0; j < K; j++) begin
            vsum_ff[j] <= '0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         out_valid_ff <= out_valid_in;
         for (int j = 0; j < K; j++) begin
            vsum_ff[j] <= vsum_in[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_tag_ff    <= s1_tag_in;
      s1_pixel_ff  <= s1_pixel_in;
      s1_col_ff    <= s1_col_in;
      s2_border_ff <= s2_border_in;
      s2_last_ff   <= s2_last_in;
      for (int j = 0; j < K; j++) begin
         s2_vsum_ff[j] <= s2_vsum_in[j];
      end
      s3_border_ff <= s3_border_in;
      s3_last_ff   <= s3_last_in;
      s3_sum_ff    <= s3_sum_in;
      out_pixel_ff <= out_pixel_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_payload.pixel_out = out_pixel_ff;
   assign rsp_payload.frame_end = out_last_ff;

   `TSM_ASSERT(a_last_on_border, clock, reset,
      out_valid_ff && out_last_ff |-> out_pixel_ff == '0, "frame end result not on border")
   `TSM_ASSERT(a_s1_hold, clock, reset,
      s1_valid_ff && s1_tag_ff.emit && !s2_ready |=> s1_valid_ff && $stable(s1_col_ff),
      "stage 1 item lost while stage 2 blocked")
   `TSM_ASSERT(a_s3_hold, clock, reset,
      s3_valid_ff && !out_ready |=> s3_valid_ff && $stable(s3_sum_ff),
      "kernel sum lost while result register blocked")
   `TSM_ASSERT(a_wr_only_shift, clock, reset,
      wr_en |-> s1_valid_ff && s1_tag_ff.shift && !s1_tag_ff.last,
      "line store written by a flush item")

endmodule

>>> rtl/triangular_smoothing_5x5_top.sv
// 5x5 triangular smoothing filter, one pixel per clock while neither side stalls.
// An item that yields a result passes stage 1, the window snapshot, the kernel sum and the
// result register in that order; a stall on the output side can hold it in any of them.
// Throughput: one item per cycle while not stalled, set by the line-store RAM (one read, one write).
// Reset (synchronous): counters, window sums and pipeline cleared; registers
// return to 640 x 480. Line-store contents are not cleared.
module triangular_smoothing_5x5_top #(
   parameter int MAX_WIDTH  = tsm_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = tsm_pkg::DEFAULT_MAX_HEIGHT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  tsm_pkg::req_payload_type        req_payload,
   output logic                            req_stall,
   output logic                            rsp_valid,
   output tsm_pkg::rsp_payload_type        rsp_payload,
   input  logic                            rsp_stall,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tsm_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [tsm_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [tsm_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int LINE_W = tsm_pkg::NLINES * tsm_pkg::PIX_W;

   logic [tsm_pkg::WIDTH_REG_W-1:0]  image_width;
   logic [tsm_pkg::HEIGHT_REG_W-1:0] image_height;
   logic                             restart;
   logic                             s1_ready;
   logic                             item_load;
   tsm_pkg::item_tag_type            item_tag;
   logic [tsm_pkg::PIX_W-1:0]        item_pixel;
   logic [COL_W-1:0]                 item_col;
   logic                             rd_en;
   logic [COL_W-1:0]                 rd_addr;
   logic [LINE_W-1:0]                rd_data;
   logic                             wr_en;
   logic [COL_W-1:0]                 wr_addr;
   logic [LINE_W-1:0]                wr_data;

   tsm_csr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .image_width  (image_width),
      .image_height (image_height),
      .restart      (restart)
   );

   tsm_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_payload  (req_payload),
      .req_stall    (req_stall),
      .image_width  (image_width),
      .image_height (image_height),
      .restart      (restart),
      .s1_ready     (s1_ready),
      .item_load    (item_load),
      .item_tag     (item_tag),
      .item_pixel   (item_pixel),
      .item_col     (item_col),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr)
   );

   // four line stores side by side, one word per column
   tsm_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tsm_filter #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_filter (
      .clock       (clock),
      .reset       (reset),
      .item_load   (item_load),
      .item_tag    (item_tag),
      .item_pixel  (item_pixel),
      .item_col    (item_col),
      .s1_ready    (s1_ready),
      .rd_data     (rd_data),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .rsp_stall   (rsp_stall)
   );

endmodule
